[rtl/bas_pkg.sv]
// package: shared types and constants for the bezier splat block
package bas_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned PosW   = 26;
  localparam int unsigned TW     = 17;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_e;

  localparam logic [TW-1:0] OneQ16 = 17'd65536;

endpackage

[rtl/bas_lerp.sv]
// module: one registered de casteljau interpolation stage for one coordinate (x or y)
module bas_lerp (
  input  logic                         clk_i,
  input  logic [bas_pkg::TW-1:0]       t_i,
  input  logic [bas_pkg::PosW-1:0]     a_i,
  input  logic [bas_pkg::PosW-1:0]     b_i,
  output logic [bas_pkg::PosW-1:0]     r_o
);
  localparam int unsigned ProdW = bas_pkg::PosW + bas_pkg::TW + 2;
  localparam int unsigned SumW  = ProdW + 1;

  // ((1-t)*a + t*b + half) >> 16, written as a + t*(b-a) with rounding
  logic signed [bas_pkg::PosW:0]       diff;
  logic signed [ProdW-1:0]             prod;
  logic signed [SumW-1:0]              sum;
  logic [bas_pkg::PosW-1:0]            r_d;

  always_comb begin
    diff = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    prod = ProdW'($signed({1'b0, t_i})) * ProdW'(diff);
    sum  = SumW'($signed({1'b0, a_i, 16'd0})) + SumW'(prod) + SumW'(32768);
    r_d  = sum[bas_pkg::PosW+15:16];
  end

  always_ff @(posedge clk_i) begin
    r_o <= r_d;
  end
endmodule

[rtl/bezier_antialiased_splat.sv]
// module: top level of the antialiased cubic bezier splat
// usage:
//   write the eight control point registers through cfg_we_i, cfg_idx_i and
//   cfg_data_i while the block is idle; only the low 10 bits are kept.
//   a transfer of t_value_i is taken when start_i is high and busy_o is low.
//   each transfer yields nine result transfers, one per cycle, each marked by
//   res_valid_o for one cycle, dx-major dy-minor, last_o on the ninth.
//   the first result reaches the outputs after the input transfer passes
//   through a t register, three lerp stages, a rounding stage, an offset
//   stage, the emitter latch, a squared distance stage and a weight stage.
//   the single result channel bounds the item rate, but a new item can be taken
//   before the earlier one has left the emitter: busy_o is high while an earlier
//   item is still in the front stages or the emitter has more than seven results
//   left, so the nine results of the next item can follow the earlier ones with no gap.
//   the receiver cannot stall; results are simply presented.
//   reset clears the control point registers to zero and empties the pipeline.
module bezier_antialiased_splat #(
  parameter int unsigned FRAME_WIDTH  = 1024,
  parameter int unsigned FRAME_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bas_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bas_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                         start_i,
  input  logic [bas_pkg::TW-1:0]       t_value_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output logic signed [11:0]           pix_x_o,
  output logic signed [11:0]           pix_y_o,
  output logic [7:0]                   weight_o,
  output logic                         inside_res_o,
  output logic                         last_o
);
  localparam int unsigned PW = bas_pkg::PosW;

  logic [bas_pkg::CoordW-1:0] px_q [4];
  logic [bas_pkg::CoordW-1:0] py_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (bas_pkg::reg_idx_e'(cfg_idx_i))
        bas_pkg::REG_P0_X: px_q[0] <= cfg_data_i;
        bas_pkg::REG_P0_Y: py_q[0] <= cfg_data_i;
        bas_pkg::REG_P1_X: px_q[1] <= cfg_data_i;
        bas_pkg::REG_P1_Y: py_q[1] <= cfg_data_i;
        bas_pkg::REG_P2_X: px_q[2] <= cfg_data_i;
        bas_pkg::REG_P2_Y: py_q[2] <= cfg_data_i;
        bas_pkg::REG_P3_X: px_q[3] <= cfg_data_i;
        bas_pkg::REG_P3_Y: py_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // emitter slot counter
  logic [3:0] cnt_q, cnt_d;
  logic       acc;
  logic [5:0] vld_q, vld_d;

  // at most one item in the front stages at a time; a new one is taken once the emitter has at most seven results left
  assign busy_o = (vld_q != '0) || (cnt_q > 4'd7);
  assign acc    = start_i && !busy_o;

  // stage 0: saturate t, then delay it for the later lerp stages
  logic [bas_pkg::TW-1:0] t0_q, t1_q, t2_q;
  always_ff @(posedge clk_i) begin
    t0_q <= (t_value_i > bas_pkg::OneQ16) ? bas_pkg::OneQ16 : t_value_i;
    t1_q <= t0_q;
    t2_q <= t1_q;
  end

  // three lerp stages per axis
  logic [PW-1:0] xa1, xb1, xc1, xa2, xb2, xr;
  logic [PW-1:0] ya1, yb1, yc1, ya2, yb2, yr;
  logic [PW-1:0] ex0 [4];
  logic [PW-1:0] ey0 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ex0[i] = {px_q[i], 16'd0};
      ey0[i] = {py_q[i], 16'd0};
    end
  end

  bas_lerp u_xa1 (.clk_i, .t_i(t0_q), .a_i(ex0[0]), .b_i(ex0[1]), .r_o(xa1));
  bas_lerp u_xb1 (.clk_i, .t_i(t0_q), .a_i(ex0[1]), .b_i(ex0[2]), .r_o(xb1));
  bas_lerp u_xc1 (.clk_i, .t_i(t0_q), .a_i(ex0[2]), .b_i(ex0[3]), .r_o(xc1));
  bas_lerp u_ya1 (.clk_i, .t_i(t0_q), .a_i(ey0[0]), .b_i(ey0[1]), .r_o(ya1));
  bas_lerp u_yb1 (.clk_i, .t_i(t0_q), .a_i(ey0[1]), .b_i(ey0[2]), .r_o(yb1));
  bas_lerp u_yc1 (.clk_i, .t_i(t0_q), .a_i(ey0[2]), .b_i(ey0[3]), .r_o(yc1));
  bas_lerp u_xa2 (.clk_i, .t_i(t1_q), .a_i(xa1), .b_i(xb1), .r_o(xa2));
  bas_lerp u_xb2 (.clk_i, .t_i(t1_q), .a_i(xb1), .b_i(xc1), .r_o(xb2));
  bas_lerp u_ya2 (.clk_i, .t_i(t1_q), .a_i(ya1), .b_i(yb1), .r_o(ya2));
  bas_lerp u_yb2 (.clk_i, .t_i(t1_q), .a_i(yb1), .b_i(yc1), .r_o(yb2));
  bas_lerp u_xr  (.clk_i, .t_i(t2_q), .a_i(xa2), .b_i(xb2), .r_o(xr));
  bas_lerp u_yr  (.clk_i, .t_i(t2_q), .a_i(ya2), .b_i(yb2), .r_o(yr));

  // stage 4: pixel and fractional offset to centre of pixel x,y
  logic [10:0]        nx_q, ny_q;
  logic signed [17:0] fx_q, fy_q;
  logic [PW:0]        rx, ry;
  always_comb begin
    rx = {1'b0, xr} + (PW+1)'(32768);
    ry = {1'b0, yr} + (PW+1)'(32768);
  end
  always_ff @(posedge clk_i) begin
    nx_q <= rx[PW:16];
    ny_q <= ry[PW:16];
    fx_q <= $signed({2'b00, xr[15:0]}) - 18'sd32768 -
            (rx[16] == xr[16] ? 18'sd0 : 18'sd65536);
    fy_q <= $signed({2'b00, yr[15:0]}) - 18'sd32768 -
            (ry[16] == yr[16] ? 18'sd0 : 18'sd65536);
  end

  // stage 5: squared offsets for dx,dy in -1..1 (e = f - d*65536)
  logic [35:0] sqx_q [3];
  logic [35:0] sqy_q [3];
  logic [10:0] nx5_q, ny5_q;
  logic signed [19:0] ox [3];
  logic signed [19:0] oy [3];
  logic signed [39:0] sqx_d [3];
  logic signed [39:0] sqy_d [3];
  always_comb begin
    ox[0] = {{2{fx_q[17]}}, fx_q} + 20'sd65536;
    ox[1] = {{2{fx_q[17]}}, fx_q};
    ox[2] = {{2{fx_q[17]}}, fx_q} - 20'sd65536;
    oy[0] = {{2{fy_q[17]}}, fy_q} + 20'sd65536;
    oy[1] = {{2{fy_q[17]}}, fy_q};
    oy[2] = {{2{fy_q[17]}}, fy_q} - 20'sd65536;
    for (int d = 0; d < 3; d++) begin
      sqx_d[d] = 40'(ox[d]) * 40'(ox[d]);
      sqy_d[d] = 40'(oy[d]) * 40'(oy[d]);
    end
  end
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 3; d++) begin
      sqx_q[d] <= sqx_d[d][35:0];
      sqy_q[d] <= sqy_d[d][35:0];
    end
    nx5_q <= nx_q;
    ny5_q <= ny_q;
  end

  // stage 6: latch the item into the emitter
  logic [35:0] esx_q [3];
  logic [35:0] esy_q [3];
  logic [10:0] enx_q, eny_q;
  always_ff @(posedge clk_i) begin
    if (vld_q[5]) begin
      esx_q <= sqx_q;
      esy_q <= sqy_q;
      enx_q <= nx5_q;
      eny_q <= ny5_q;
    end
  end

  always_comb begin
    vld_d = {vld_q[4:0], acc};
    cnt_d = cnt_q;
    if (vld_q[5])            cnt_d = 4'd9;
    else if (cnt_q != 4'd0)  cnt_d = cnt_q - 4'd1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  // emit one neighbour per cycle: k = 9 - cnt, dx = k/3 - 1, dy = k%3 - 1
  logic [3:0] k;
  logic [1:0] di, dj;
  logic signed [12:0] qx, qy;
  logic [36:0] s;
  logic [53:0] lhs;
  logic in_frame;
  always_comb begin
    k  = 4'd9 - cnt_q;
    di = (k >= 4'd6) ? 2'd2 : (k >= 4'd3) ? 2'd1 : 2'd0;
    dj = 2'(k - 4'(di) * 4'd3);
    qx = $signed({2'b00, enx_q}) + $signed({11'd0, di}) - 13'sd1;
    qy = $signed({2'b00, eny_q}) + $signed({11'd0, dj}) - 13'sd1;
    in_frame = (qx >= 0) && ($unsigned(qx) < 13'(FRAME_WIDTH)) &&
               (qy >= 0) && ($unsigned(qy) < 13'(FRAME_HEIGHT));
    s   = {1'b0, esx_q[di]} + {1'b0, esy_q[dj]};
    lhs = 54'(s) * 54'd65025;
  end

  // distance stage and weight output stage
  logic [53:0]        lhs_q;
  logic signed [11:0] qx_q, qy_q;
  logic               in_frame_q, emit_vld_q, emit_last_q;
  logic [7:0]         kk;
  always_comb begin
    kk = 8'd255;
    for (int j = 254; j >= 0; j--) begin
      if ((54'(j * j) << 33) >= lhs_q) kk = 8'(j);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_vld_q  <= 1'b0;
      emit_last_q <= 1'b0;
      res_valid_o <= 1'b0;
      last_o      <= 1'b0;
    end else begin
      emit_vld_q  <= (cnt_q != 4'd0);
      emit_last_q <= (cnt_q == 4'd1);
      res_valid_o <= emit_vld_q;
      last_o      <= emit_last_q;
    end
  end
  always_ff @(posedge clk_i) begin
    lhs_q        <= lhs;
    qx_q         <= qx[11:0];
    qy_q         <= qy[11:0];
    in_frame_q   <= in_frame;
    pix_x_o      <= qx_q;
    pix_y_o      <= qy_q;
    inside_res_o <= in_frame_q;
    weight_o     <= in_frame_q ? (8'd255 - kk) : 8'd0;
  end

`ifndef SYNTH
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> res_valid_o) else $error("last without valid");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd9) else $error("slot counter out of range");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (cnt_q <= 4'd1)) else $error("emitter overrun");
`endif
endmodule
